// ----- hw/rtl/u8hex_pkg.sv -----
// Shared types, character codes and helper functions for the UTF-8 validator with hex escaping.
package u8hex_pkg;

    localparam logic [7:0] BACKSLASH  = 8'h5C;
    localparam logic [7:0] LETTER_X   = 8'h78;
    localparam logic [7:0] FIRST_TEXT = 8'h20;
    localparam logic [7:0] LEAD_C0    = 8'hC0;

    // One item's worth of output work: some held bytes, then possibly the current byte.
    typedef struct packed {
        logic [2:0][7:0] held;
        logic [1:0]      n_held;
        logic            held_esc;
        logic            has_cur;
        logic [7:0]      cur;
        logic            cur_esc;
        logic            text_end;
    } run_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
    endfunction

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7:5] == 3'b110)
        begin
            len = 3'd2;
        end
        else if (b[7:4] == 4'b1110)
        begin
            len = 3'd3;
        end
        else if (b[7:3] == 5'b11110)
        begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Code points that are refused whatever the encoding length.
    function automatic logic bad_point(input logic [20:0] u);
        return (u == 21'h00FFFE) || (u == 21'h00FFFF)
            || (u >= 21'h00D800 && u <= 21'h00DFFF)
            || (u > 21'h013FFF && u < 21'h016000)
            || (u > 21'h016FFF && u < 21'h01B000)
            || (u > 21'h01BFFF && u < 21'h01D000)
            || (u > 21'h02BFFF && u < 21'h02F000)
            || (u >= 21'h030000 && u < 21'h0DFFFF)
            || (u > 21'h10FFFF);
    endfunction

endpackage

// ----- hw/rtl/u8hex_emit.sv -----
// Result register and serialiser that turns one run into output bytes and escape characters.
module u8hex_emit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  u8hex_pkg::run_t   run_in,
    input  logic              res_stall,
    output logic              run_free,
    output logic              res_valid,
    output logic [7:0]        out_byte,
    output logic              run_last,
    output logic              text_last
);

    u8hex_pkg::run_t run_reg;
    logic            valid_reg;
    logic [1:0]      unit_reg;
    logic [1:0]      char_reg;

    logic [2:0] units_total;
    logic       cur_is_held;
    logic [7:0] byte_sel;
    logic       esc_sel;
    logic       unit_end;
    logic       last_unit;
    logic       step;
    logic       finishing;

    always_comb
    begin
        units_total = {1'b0, run_reg.n_held} + {2'b00, run_reg.has_cur};
        cur_is_held = unit_reg < run_reg.n_held;
        byte_sel    = run_reg.cur;
        if (cur_is_held)
        begin
            unique case (unit_reg)
                2'd0:    byte_sel = run_reg.held[0];
                2'd1:    byte_sel = run_reg.held[1];
                default: byte_sel = run_reg.held[2];
            endcase
        end
        esc_sel   = cur_is_held ? run_reg.held_esc : run_reg.cur_esc;
        unit_end  = !esc_sel || (char_reg == 2'd3);
        last_unit = ({1'b0, unit_reg} == (units_total - 3'd1));

        out_byte = byte_sel;
        if (esc_sel)
        begin
            unique case (char_reg)
                2'd0:    out_byte = u8hex_pkg::BACKSLASH;
                2'd1:    out_byte = u8hex_pkg::LETTER_X;
                2'd2:    out_byte = u8hex_pkg::hex_digit(byte_sel[7:4]);
                default: out_byte = u8hex_pkg::hex_digit(byte_sel[3:0]);
            endcase
        end

        run_last  = unit_end && last_unit;
        text_last = run_last && run_reg.text_end;
        res_valid = valid_reg;
        step      = valid_reg && !res_stall;
        finishing = step && run_last;
        run_free  = !valid_reg || finishing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            unit_reg  <= 2'd0;
            char_reg  <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            unit_reg  <= 2'd0;
            char_reg  <= 2'd0;
        end
        else if (finishing)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            if (unit_end)
            begin
                unit_reg <= unit_reg + 2'd1;
                char_reg <= 2'd0;
            end
            else
            begin
                char_reg <= char_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_reg <= run_in;
        end
    end

endmodule

// ----- hw/rtl/utf8_validate_hex_escape_top.sv -----
// UTF-8 validator top: passes good sequences, hex-escapes the rest, controls and backslash.
// Input bytes are taken one per cycle into an input register, unless it is still full and the
// result register is busy. From the bytes held so far it is decided what that byte releases,
// which is loaded into the result register; that register is freed in the same cycle as its
// last output byte is taken. On the result side each passed byte gives one output byte and
// each escaped byte four (backslash, x, two hex digits); one item releases up to four bytes.
// A byte that is only held releases nothing to the output.
module utf8_validate_hex_escape_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_last
);

    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       a_end_reg;

    logic [2:0][7:0] held_reg;
    logic [1:0]      hcount_reg;
    logic [1:0]      hcount_next;
    logic [2:0]      slen_reg;
    logic [2:0]      slen_next;

    logic            run_free;
    logic            a_take;
    logic            load;
    logic            hold_write;
    logic [1:0]      hold_index;
    u8hex_pkg::run_t run;

    logic       fresh_path;
    logic       is_cont;
    logic [2:0] lead;
    logic       tf_hold;
    logic       tf_esc;
    logic [20:0] code_point;
    logic       bad;

    assign a_take   = a_valid_reg && run_free;
    assign in_stall = a_valid_reg && !a_take;
    assign load     = a_take && ((run.n_held != 2'd0) || run.has_cur);

    always_comb
    begin
        fresh_path = (hcount_reg == 2'd0) || (slen_reg < 3'd2) || (slen_reg > 3'd4);
        is_cont    = (a_byte_reg[7:6] == 2'b10);
        lead       = u8hex_pkg::lead_length(a_byte_reg);
        tf_hold    = a_byte_reg[7] && (lead != 3'd0) && !a_end_reg;
        tf_esc     = a_byte_reg[7] || (a_byte_reg < u8hex_pkg::FIRST_TEXT)
                     || (a_byte_reg == u8hex_pkg::BACKSLASH);

        unique case (slen_reg)
            3'd2:
            begin
                code_point = {10'd0, held_reg[0][4:0], a_byte_reg[5:0]};
                bad = (held_reg[0] == u8hex_pkg::LEAD_C0) || (code_point <= 21'h00007F);
            end
            3'd3:
            begin
                code_point = {5'd0, held_reg[0][3:0], held_reg[1][5:0], a_byte_reg[5:0]};
                bad = (code_point <= 21'h0007FF);
            end
            default:
            begin
                code_point = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                              a_byte_reg[5:0]};
                bad = (code_point < 21'h010000);
            end
        endcase
        bad = bad || u8hex_pkg::bad_point(code_point);
    end

    always_comb
    begin
        run.held     = held_reg;
        run.n_held   = 2'd0;
        run.held_esc = 1'b1;
        run.has_cur  = 1'b0;
        run.cur      = a_byte_reg;
        run.cur_esc  = tf_esc;
        run.text_end = a_end_reg;
        hcount_next  = hcount_reg;
        slen_next    = slen_reg;
        hold_write   = 1'b0;
        hold_index   = 2'd0;

        priority if (fresh_path || !is_cont)
        begin
            // A broken sequence releases its held bytes before the new byte starts afresh.
            run.n_held  = fresh_path ? 2'd0 : hcount_reg;
            run.has_cur = !tf_hold;
            if (tf_hold)
            begin
                hold_write  = 1'b1;
                hold_index  = 2'd0;
                hcount_next = 2'd1;
                slen_next   = lead;
            end
            else
            begin
                hcount_next = 2'd0;
                slen_next   = 3'd0;
            end
        end
        else if (({1'b0, hcount_reg} + 3'd1) >= slen_reg)
        begin
            run.n_held   = 2'(slen_reg - 3'd1);
            run.held_esc = bad;
            run.has_cur  = 1'b1;
            run.cur_esc  = bad;
            hcount_next  = 2'd0;
            slen_next    = 3'd0;
        end
        else if (a_end_reg)
        begin
            run.n_held  = hcount_reg;
            run.has_cur = 1'b1;
            run.cur_esc = 1'b1;
            hcount_next = 2'd0;
            slen_next   = 3'd0;
        end
        else
        begin
            hold_write  = 1'b1;
            hold_index  = hcount_reg;
            hcount_next = hcount_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            hcount_reg  <= 2'd0;
            slen_reg    <= 3'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_take)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_take)
            begin
                hcount_reg <= hcount_next;
                slen_reg   <= slen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            a_byte_reg <= data_byte;
            a_end_reg  <= end_of_text;
        end
        if (a_take && hold_write)
        begin
            unique case (hold_index)
                2'd0:    held_reg[0] <= a_byte_reg;
                2'd1:    held_reg[1] <= a_byte_reg;
                default: held_reg[2] <= a_byte_reg;
            endcase
        end
    end

    u8hex_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .run_in    (run),
        .res_stall (res_stall),
        .run_free  (run_free),
        .res_valid (res_valid),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_last (text_last)
    );

endmodule

// ----- hw/rtl/u8hex_checker.sv -----
// Port-level checks on the validator's result stream, bound to the top level.
module u8hex_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_stall,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       text_last
);

    // The end of the text always closes the results of its item.
    a_text_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && text_last |-> run_last)
        else $error("text_last without run_last");

    // Controls are always escaped, so they never reach the output.
    a_no_control_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (out_byte >= u8hex_pkg::FIRST_TEXT))
        else $error("control byte on output");

    // A backslash on the output only opens an escape, so it never ends an item.
    a_backslash_opens_escape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (out_byte == u8hex_pkg::BACKSLASH) |-> !run_last)
        else $error("backslash ends an item");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(run_last))
        else $error("stalled result changed");

endmodule

bind utf8_validate_hex_escape_top u8hex_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_last (text_last)
);
